// ===== rtl/esd_pkg.sv =====
`timescale 1ns / 1ps

package esd_pkg;

   // parse phases
   typedef enum logic [3:0] {
      PH_TAG1   = 4'd0,
      PH_HSIZE  = 4'd1,
      PH_HDR    = 4'd2,
      PH_TAG2   = 4'd3,
      PH_DLEN   = 4'd4,
      PH_EVID   = 4'd5,
      PH_NUM1   = 4'd6,
      PH_NUM2   = 4'd7,
      PH_NUM4   = 4'd8,
      PH_VARINT = 4'd9,
      PH_TEXT   = 4'd10,
      PH_QUIET  = 4'd11
   } phase_type;

   // result kinds
   localparam logic [2:0] KIND_HEADER     = 3'd0;
   localparam logic [2:0] KIND_BYTE       = 3'd1;
   localparam logic [2:0] KIND_WORD       = 3'd2;
   localparam logic [2:0] KIND_DWORD      = 3'd3;
   localparam logic [2:0] KIND_TEXT_START = 3'd4;
   localparam logic [2:0] KIND_TEXT_BYTE  = 3'd5;
   localparam logic [2:0] KIND_ERROR      = 3'd6;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_FIRST_TAG  = 3'd1;
   localparam logic [2:0] ERR_HDR_SIZE   = 3'd2;
   localparam logic [2:0] ERR_DATA_TAG   = 3'd3;
   localparam logic [2:0] ERR_LEN_OVFL   = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_WORD_ID_BASE  = 2'd0;
   localparam logic [1:0] CSR_DWORD_ID_BASE = 2'd1;
   localparam logic [1:0] CSR_TEXT_ID_BASE  = 2'd2;

   // chunk tags, little-endian words
   localparam logic [31:0] TAG_HEAD    = 32'h6468_4C46;
   localparam logic [31:0] TAG_DATA    = 32'h7464_4C46;
   localparam logic [31:0] HEADER_SIZE = 32'd6;
   localparam logic [5:0]  VARINT_LAST_SHIFT = 6'd28;
   localparam logic [5:0]  VARINT_STEP = 6'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  event_id;
      logic [31:0] value;
      logic [15:0] channel_count;
      logic [15:0] pulses_per_quarter;
      logic [7:0]  text_byte;
      logic        last;
      logic [2:0]  error_code;
   } result_type;

   typedef struct packed {
      logic [7:0] word_id_base;
      logic [7:0] dword_id_base;
      logic [7:0] text_id_base;
   } bases_type;

endpackage

// ===== rtl/project_event_stream_deframer.sv =====
`timescale 1ns / 1ps

// channel   | ports                                  | handshake
// ----------+----------------------------------------+-----------------------
// request   | req_in_byte                            | req_valid / req_ready
// response  | rsp_kind .. rsp_error_code (8 fields)  | rsp_valid / rsp_ready
// csr       | csr_index, csr_wdata                   | csr_we, no wait
//
// one byte per cycle unless a held response stalls input; each request
// transaction updates the parse state in the cycle it is accepted, and any
// response shows up in the next cycle from the output register. req_ready is
// low only while a response sits in the output register and rsp_ready is low.
// synchronous reset returns the parser to the first header tag and the id bases
// to 64/128/192. after an error response all bytes are swallowed until reset.

module project_event_stream_deframer (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_event_id,
   output logic [31:0] rsp_value,
   output logic [15:0] rsp_channel_count,
   output logic [15:0] rsp_pulses_per_quarter,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_last,
   output logic [2:0]  rsp_error_code,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import esd_pkg::*;

   bases_type  bases_ff;
   logic       step;
   logic       core_res_valid;
   result_type core_res;
   logic       out_can_take;
   result_type out_data;

   // id threshold registers, index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         bases_ff.word_id_base  <= 8'd64;
         bases_ff.dword_id_base <= 8'd128;
         bases_ff.text_id_base  <= 8'd192;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WORD_ID_BASE:  bases_ff.word_id_base  <= csr_wdata;
            CSR_DWORD_ID_BASE: bases_ff.dword_id_base <= csr_wdata;
            CSR_TEXT_ID_BASE:  bases_ff.text_id_base  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a byte is taken whenever the output register can absorb its result
   assign req_ready = out_can_take;
   assign step      = req_valid && req_ready;

   esd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (req_in_byte),
      .bases     (bases_ff),
      .res_valid (core_res_valid),
      .res       (core_res)
   );

   esd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step && core_res_valid),
      .load_data (core_res),
      .can_take  (out_can_take),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_kind               = out_data.kind;
   assign rsp_event_id           = out_data.event_id;
   assign rsp_value              = out_data.value;
   assign rsp_channel_count      = out_data.channel_count;
   assign rsp_pulses_per_quarter = out_data.pulses_per_quarter;
   assign rsp_text_byte          = out_data.text_byte;
   assign rsp_last               = out_data.last;
   assign rsp_error_code         = out_data.error_code;

   // backpressure only comes from a held response
   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with empty output register");

   // an error response always carries a code
   a_error_has_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ERROR) |-> (rsp_error_code != ERR_NONE))
      else $error("error response without error code");

   // parser goes quiet after an error, so nothing follows it
   a_quiet_after_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_kind == KIND_ERROR) |=> !rsp_valid)
      else $error("response after error");

   // text start flags last exactly for zero length
   a_text_start_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_TEXT_START) |-> (rsp_last == (rsp_value == 32'd0)))
      else $error("text start last flag mismatch");

endmodule

// ===== rtl/esd_core.sv =====
`timescale 1ns / 1ps

module esd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          in_byte,
   input  esd_pkg::bases_type  bases,
   output logic                res_valid,
   output esd_pkg::result_type res
);
   import esd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  byte_count_ff, byte_count_in;
   logic [31:0] gathered_ff, gathered_in;
   logic [7:0]  current_id_ff, current_id_in;
   logic [5:0]  varint_shift_ff, varint_shift_in;
   logic [31:0] text_left_ff, text_left_in;
   logic [15:0] saved_format_ff, saved_format_in;
   logic [15:0] saved_channels_ff, saved_channels_in;

   logic [31:0] lane_merged;
   logic        word_done;
   logic        tag_ok;
   logic        num_done;
   logic        varint_bad;
   logic [31:0] varint_sum;
   logic        text_last;

   assign lane_merged = gathered_ff | ({24'd0, in_byte} << {byte_count_ff[1:0], 3'b000});
   assign word_done   = (byte_count_ff[1:0] == 2'd3);
   assign varint_bad  = (varint_shift_ff > VARINT_LAST_SHIFT) ||
                        ((varint_shift_ff == VARINT_LAST_SHIFT) && (in_byte[7:4] != 4'd0));
   assign varint_sum  = gathered_ff | ({25'd0, in_byte[6:0]} << varint_shift_ff);
   assign text_last   = (text_left_ff <= 32'd1);

   always_comb begin
      case (phase_ff)
         PH_TAG1:  tag_ok = (lane_merged == TAG_HEAD);
         PH_HSIZE: tag_ok = (lane_merged == HEADER_SIZE);
         PH_TAG2:  tag_ok = (lane_merged == TAG_DATA);
         default:  tag_ok = 1'b1;
      endcase
   end

   always_comb begin
      case (phase_ff)
         PH_NUM1: num_done = (byte_count_ff == 3'd0);
         PH_NUM2: num_done = (byte_count_ff == 3'd1);
         default: num_done = (byte_count_ff == 3'd3);
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_TAG1: if (word_done) phase_in = tag_ok ? PH_HSIZE : PH_QUIET;
         PH_HSIZE: if (word_done) phase_in = tag_ok ? PH_HDR : PH_QUIET;
         PH_TAG2: if (word_done) phase_in = tag_ok ? PH_DLEN : PH_QUIET;
         PH_DLEN: if (word_done) phase_in = PH_EVID;
         PH_HDR: if (byte_count_ff >= 3'd5) phase_in = PH_TAG2;
         PH_EVID: begin
            if (in_byte >= bases.text_id_base)       phase_in = PH_VARINT;
            else if (in_byte >= bases.dword_id_base) phase_in = PH_NUM4;
            else if (in_byte >= bases.word_id_base)  phase_in = PH_NUM2;
            else                                     phase_in = PH_NUM1;
         end
         PH_NUM1, PH_NUM2, PH_NUM4: if (num_done) phase_in = PH_EVID;
         PH_VARINT: begin
            if (varint_bad)        phase_in = PH_QUIET;
            else if (!in_byte[7])  phase_in = (varint_sum == 32'd0) ? PH_EVID : PH_TEXT;
         end
         PH_TEXT: if (text_last) phase_in = PH_EVID;
         default: phase_in = PH_QUIET;
      endcase
   end

   // datapath and result
   always_comb begin
      byte_count_in     = byte_count_ff;
      gathered_in       = gathered_ff;
      current_id_in     = current_id_ff;
      varint_shift_in   = varint_shift_ff;
      text_left_in      = text_left_ff;
      saved_format_in   = saved_format_ff;
      saved_channels_in = saved_channels_ff;
      res_valid         = 1'b0;
      res               = '0;
      case (phase_ff)
         PH_TAG1, PH_HSIZE, PH_TAG2, PH_DLEN: begin
            if (word_done) begin
               byte_count_in = 3'd0;
               gathered_in   = 32'd0;
               if (!tag_ok) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_ERROR;
                  case (phase_ff)
                     PH_TAG1:  res.error_code = ERR_FIRST_TAG;
                     PH_HSIZE: res.error_code = ERR_HDR_SIZE;
                     default:  res.error_code = ERR_DATA_TAG;
                  endcase
               end
            end else begin
               byte_count_in = byte_count_ff + 3'd1;
               gathered_in   = lane_merged;
            end
         end
         PH_HDR: begin
            byte_count_in = byte_count_ff + 3'd1;
            case (byte_count_ff)
               3'd0: saved_format_in = {8'd0, in_byte};
               3'd1: saved_format_in = {in_byte, saved_format_ff[7:0]};
               3'd2: saved_channels_in = {8'd0, in_byte};
               3'd3: saved_channels_in = {in_byte, saved_channels_ff[7:0]};
               3'd4: gathered_in = {24'd0, in_byte};
               default: begin
                  res_valid              = 1'b1;
                  res.kind               = KIND_HEADER;
                  res.value              = {16'd0, saved_format_ff};
                  res.channel_count      = saved_channels_ff;
                  res.pulses_per_quarter = {in_byte, gathered_ff[7:0]};
                  gathered_in            = 32'd0;
                  byte_count_in          = 3'd0;
               end
            endcase
         end
         PH_EVID: begin
            current_id_in   = in_byte;
            gathered_in     = 32'd0;
            byte_count_in   = 3'd0;
            varint_shift_in = 6'd0;
         end
         PH_NUM1, PH_NUM2, PH_NUM4: begin
            if (num_done) begin
               res_valid     = 1'b1;
               res.kind      = (phase_ff == PH_NUM1) ? KIND_BYTE :
                               (phase_ff == PH_NUM2) ? KIND_WORD : KIND_DWORD;
               res.event_id  = current_id_ff;
               res.value     = lane_merged;
               gathered_in   = 32'd0;
               byte_count_in = 3'd0;
            end else begin
               gathered_in   = lane_merged;
               byte_count_in = byte_count_ff + 3'd1;
            end
         end
         PH_VARINT: begin
            if (varint_bad) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.event_id   = current_id_ff;
               res.error_code = ERR_LEN_OVFL;
            end else if (in_byte[7]) begin
               gathered_in     = varint_sum;
               varint_shift_in = varint_shift_ff + VARINT_STEP;
            end else begin
               text_left_in    = varint_sum;
               gathered_in     = 32'd0;
               varint_shift_in = 6'd0;
               res_valid       = 1'b1;
               res.kind        = KIND_TEXT_START;
               res.event_id    = current_id_ff;
               res.value       = varint_sum;
               res.last        = (varint_sum == 32'd0);
            end
         end
         PH_TEXT: begin
            res_valid     = 1'b1;
            res.kind      = KIND_TEXT_BYTE;
            res.event_id  = current_id_ff;
            res.text_byte = in_byte;
            res.last      = text_last;
            text_left_in  = text_last ? 32'd0 : text_left_ff - 32'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_TAG1;
         byte_count_ff     <= 3'd0;
         gathered_ff       <= 32'd0;
         current_id_ff     <= 8'd0;
         varint_shift_ff   <= 6'd0;
         text_left_ff      <= 32'd0;
         saved_format_ff   <= 16'd0;
         saved_channels_ff <= 16'd0;
      end else if (step) begin
         phase_ff          <= phase_in;
         byte_count_ff     <= byte_count_in;
         gathered_ff       <= gathered_in;
         current_id_ff     <= current_id_in;
         varint_shift_ff   <= varint_shift_in;
         text_left_ff      <= text_left_in;
         saved_format_ff   <= saved_format_in;
         saved_channels_ff <= saved_channels_in;
      end
   end

endmodule

// ===== rtl/esd_out_stage.sv =====
`timescale 1ns / 1ps

module esd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  esd_pkg::result_type load_data,
   output logic                can_take,
   output logic                out_valid,
   input  logic                out_ready,
   output esd_pkg::result_type out_data
);
   import esd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // free when empty or being drained this cycle
   assign can_take = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== tb/sv/project_event_stream_deframer_test.sv =====
`timescale 1ns / 1ps

module project_event_stream_deframer_test;
   import esd_pkg::*;

   // cycles with no transaction on either channel before the run is abandoned
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   // random stream bytes per base setting, and number of settings
   localparam int unsigned BYTES_PER_SETTING = 125;
   localparam int unsigned SETTING_COUNT = 8;

   // ------------------------------------------------------------------
   // scoreboard: own copy of the parser state, the id bases, and the
   // queue of results the parser should produce
   // ------------------------------------------------------------------
   class deframe_scoreboard;
      result_type predicted_results[$];
      int unsigned mismatch_count;
      logic [7:0] word_base;
      logic [7:0] dword_base;
      logic [7:0] text_base;
      phase_type phase;
      logic [2:0] byte_count;
      logic [31:0] gathered;
      logic [7:0] current_id;
      logic [5:0] varint_shift;
      logic [31:0] text_left;
      logic [15:0] saved_format;
      logic [15:0] saved_channels;

      function new();
         mismatch_count = 0;
         word_base = 8'd64;
         dword_base = 8'd128;
         text_base = 8'd192;
         phase = PH_TAG1;
         byte_count = '0;
         gathered = '0;
         current_id = '0;
         varint_shift = '0;
         text_left = '0;
         saved_format = '0;
         saved_channels = '0;
      endfunction

      // text is tested first, then dword, then word
      function logic [2:0] payload_kind(logic [7:0] id);
         if (id >= text_base) return KIND_TEXT_START;
         if (id >= dword_base) return KIND_DWORD;
         if (id >= word_base) return KIND_WORD;
         return KIND_BYTE;
      endfunction

      // error result; parser goes quiet for good
      function result_type fault(logic [7:0] id, logic [2:0] code);
         result_type r;
         r = '0;
         r.kind = KIND_ERROR;
         r.event_id = id;
         r.error_code = code;
         phase = PH_QUIET;
         return r;
      endfunction

      function void parse_byte(logic [7:0] b);
         result_type r;
         logic [31:0] word;
         logic [2:0] need;
         bit produced;
         r = '0;
         produced = 0;
         case (phase)
            PH_TAG1, PH_HSIZE, PH_TAG2, PH_DLEN: begin
               gathered = gathered | ({24'd0, b} << (8 * byte_count[1:0]));
               byte_count = byte_count + 3'd1;
               if (byte_count == 3'd4) begin
                  byte_count = '0;
                  word = gathered;
                  gathered = '0;
                  case (phase)
                     PH_TAG1: begin
                        if (word != TAG_HEAD) begin
                           r = fault(8'd0, ERR_FIRST_TAG);
                           produced = 1;
                        end else phase = PH_HSIZE;
                     end
                     PH_HSIZE: begin
                        if (word != HEADER_SIZE) begin
                           r = fault(8'd0, ERR_HDR_SIZE);
                           produced = 1;
                        end else phase = PH_HDR;
                     end
                     PH_TAG2: begin
                        if (word != TAG_DATA) begin
                           r = fault(8'd0, ERR_DATA_TAG);
                           produced = 1;
                        end else phase = PH_DLEN;
                     end
                     default: phase = PH_EVID;
                  endcase
               end
            end
            PH_HDR: begin
               if (byte_count == 3'd5) begin
                  r.kind = KIND_HEADER;
                  r.value = {16'd0, saved_format};
                  r.channel_count = saved_channels;
                  r.pulses_per_quarter = {b, gathered[7:0]};
                  produced = 1;
                  gathered = '0;
                  byte_count = '0;
                  phase = PH_TAG2;
               end else begin
                  case (byte_count)
                     3'd0: saved_format = {8'd0, b};
                     3'd1: saved_format[15:8] = b;
                     3'd2: saved_channels = {8'd0, b};
                     3'd3: saved_channels[15:8] = b;
                     default: gathered = {24'd0, b};
                  endcase
                  byte_count = byte_count + 3'd1;
               end
            end
            PH_EVID: begin
               current_id = b;
               gathered = '0;
               byte_count = '0;
               varint_shift = '0;
               case (payload_kind(b))
                  KIND_TEXT_START: phase = PH_VARINT;
                  KIND_DWORD: phase = PH_NUM4;
                  KIND_WORD: phase = PH_NUM2;
                  default: phase = PH_NUM1;
               endcase
            end
            PH_NUM1, PH_NUM2, PH_NUM4: begin
               need = (phase == PH_NUM1) ? 3'd1 : (phase == PH_NUM2) ? 3'd2 : 3'd4;
               gathered = gathered | ({24'd0, b} << (8 * byte_count[1:0]));
               byte_count = byte_count + 3'd1;
               if (byte_count == need) begin
                  r.kind = (phase == PH_NUM1) ? KIND_BYTE :
                           (phase == PH_NUM2) ? KIND_WORD : KIND_DWORD;
                  r.event_id = current_id;
                  r.value = gathered;
                  produced = 1;
                  gathered = '0;
                  byte_count = '0;
                  phase = PH_EVID;
               end
            end
            PH_VARINT: begin
               // fifth length byte may only carry bits 28..31
               if (varint_shift > VARINT_LAST_SHIFT ||
                   (varint_shift == VARINT_LAST_SHIFT && b[7:4] != 4'd0)) begin
                  r = fault(current_id, ERR_LEN_OVFL);
                  produced = 1;
               end else begin
                  gathered = gathered | ({25'd0, b[6:0]} << varint_shift);
                  varint_shift = varint_shift + VARINT_STEP;
                  if (!b[7]) begin
                     text_left = gathered;
                     gathered = '0;
                     varint_shift = '0;
                     r.kind = KIND_TEXT_START;
                     r.event_id = current_id;
                     r.value = text_left;
                     r.last = (text_left == 32'd0);
                     produced = 1;
                     phase = (text_left == 32'd0) ? PH_EVID : PH_TEXT;
                  end
               end
            end
            PH_TEXT: begin
               r.kind = KIND_TEXT_BYTE;
               r.event_id = current_id;
               r.text_byte = b;
               r.last = (text_left <= 32'd1);
               produced = 1;
               if (text_left <= 32'd1) begin
                  text_left = '0;
                  phase = PH_EVID;
               end else text_left = text_left - 32'd1;
            end
            default: phase = PH_QUIET;
         endcase
         if (produced) predicted_results.push_back(r);
      endfunction

      task report(string what);
         $display("ERROR at %0t: %s", $time, what);
         mismatch_count++;
      endtask

      task check_result(result_type got);
         result_type want;
         if (predicted_results.size() == 0) begin
            report($sformatf("result kind %0d id %0h with nothing predicted",
                             got.kind, got.event_id));
            return;
         end
         want = predicted_results.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %0h, predicted %0h", got.kind, want.kind));
         if (got.event_id !== want.event_id)
            report($sformatf("event_id %0h, predicted %0h", got.event_id, want.event_id));
         if (got.value !== want.value)
            report($sformatf("value %0h, predicted %0h", got.value, want.value));
         if (got.channel_count !== want.channel_count)
            report($sformatf("channel_count %0h, predicted %0h",
                             got.channel_count, want.channel_count));
         if (got.pulses_per_quarter !== want.pulses_per_quarter)
            report($sformatf("pulses_per_quarter %0h, predicted %0h",
                             got.pulses_per_quarter, want.pulses_per_quarter));
         if (got.text_byte !== want.text_byte)
            report($sformatf("text_byte %0h, predicted %0h", got.text_byte, want.text_byte));
         if (got.last !== want.last)
            report($sformatf("last %0h, predicted %0h", got.last, want.last));
         if (got.error_code !== want.error_code)
            report($sformatf("error_code %0h, predicted %0h",
                             got.error_code, want.error_code));
      endtask
   endclass

   // ------------------------------------------------------------------
   // signals and block instance
   // ------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_event_id;
   logic [31:0] rsp_value;
   logic [15:0] rsp_channel_count;
   logic [15:0] rsp_pulses_per_quarter;
   logic [7:0]  rsp_text_byte;
   logic        rsp_last;
   logic [2:0]  rsp_error_code;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   deframe_scoreboard board;
   bit idle_on;
   int unsigned bytes_sent;
   int unsigned results_seen;
   int unsigned settings_used;
   int unsigned quiet_cycles;
   int unsigned header_fault;
   int unsigned phase_end;
   logic [7:0]  w_base, d_base, t_base;
   logic [7:0]  ev_id;
   logic [31:0] ev_payload;

   project_event_stream_deframer u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_in_byte            (req_in_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_kind               (rsp_kind),
      .rsp_event_id           (rsp_event_id),
      .rsp_value              (rsp_value),
      .rsp_channel_count      (rsp_channel_count),
      .rsp_pulses_per_quarter (rsp_pulses_per_quarter),
      .rsp_text_byte          (rsp_text_byte),
      .rsp_last               (rsp_last),
      .rsp_error_code         (rsp_error_code),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // driving tasks; all start and end on a rising edge
   // ------------------------------------------------------------------

   // random byte leaning toward all zeros and all ones
   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // one request transaction; valid stays high straight into the next byte
   // unless an idle burst is drawn
   task automatic send_byte(input logic [7:0] b);
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      board.parse_byte(b);
      bytes_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // header chunk plus data tag and length; bad_part picks a field to corrupt
   // (0 none, 1 first tag, 2 header size, 3 data tag)
   task automatic send_header(input int unsigned bad_part);
      logic [31:0] tag1, size, tag2, dlen;
      logic [15:0] fmt, chans, ppq;
      tag1 = TAG_HEAD;
      size = HEADER_SIZE;
      tag2 = TAG_DATA;
      dlen = $urandom;
      fmt = {rand_byte(), rand_byte()};
      chans = {rand_byte(), rand_byte()};
      ppq = {rand_byte(), rand_byte()};
      // a single flipped bit is enough to break the compare
      if (bad_part == 1) tag1 = tag1 ^ (32'd1 << $urandom_range(0, 31));
      if (bad_part == 2) size = size ^ (32'd1 << $urandom_range(0, 31));
      if (bad_part == 3) tag2 = tag2 ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) send_byte(tag1[8*i +: 8]);
      for (int i = 0; i < 4; i++) send_byte(size[8*i +: 8]);
      for (int i = 0; i < 2; i++) send_byte(fmt[8*i +: 8]);
      for (int i = 0; i < 2; i++) send_byte(chans[8*i +: 8]);
      for (int i = 0; i < 2; i++) send_byte(ppq[8*i +: 8]);
      for (int i = 0; i < 4; i++) send_byte(tag2[8*i +: 8]);
      for (int i = 0; i < 4; i++) send_byte(dlen[8*i +: 8]);
   endtask

   // one event: id, then payload shaped by the current bases; for text the
   // payload is the length, and groups can pad the varint past its minimal size
   task automatic send_event(input logic [7:0] id, input logic [31:0] payload,
                             input int unsigned groups);
      logic [2:0] k;
      int unsigned n_groups;
      k = board.payload_kind(id);
      send_byte(id);
      case (k)
         KIND_BYTE: send_byte(payload[7:0]);
         KIND_WORD: for (int i = 0; i < 2; i++) send_byte(payload[8*i +: 8]);
         KIND_DWORD: for (int i = 0; i < 4; i++) send_byte(payload[8*i +: 8]);
         default: begin
            n_groups = 1;
            while (n_groups < 5 && (payload >> (7 * n_groups)) != 0) n_groups++;
            if (groups > n_groups) n_groups = groups;
            for (int i = 0; i < n_groups; i++)
               send_byte({i != n_groups - 1, 7'(payload >> (7 * i))});
            for (int j = 0; j < payload; j++) send_byte(rand_byte());
         end
      endcase
   endtask

   // stop sending and let every predicted result come back
   task automatic drain();
      req_valid <= 1'b0;
      while (board.predicted_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_bases(input logic [7:0] w, input logic [7:0] d,
                              input logic [7:0] t);
      csr_we <= 1'b1;
      csr_index <= CSR_WORD_ID_BASE;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_DWORD_ID_BASE;
      csr_wdata <= d;
      @(posedge clock);
      csr_index <= CSR_TEXT_ID_BASE;
      csr_wdata <= t;
      @(posedge clock);
      csr_we <= 1'b0;
      board.word_base = w;
      board.dword_base = d;
      board.text_base = t;
      settings_used++;
   endtask

   // ------------------------------------------------------------------
   // response side: ready toggles in bursts, every transaction is checked
   // ------------------------------------------------------------------
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (idle_on) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result({rsp_kind, rsp_event_id, rsp_value, rsp_channel_count,
                             rsp_pulses_per_quarter, rsp_text_byte, rsp_last,
                             rsp_error_code});
         results_seen++;
      end
   end

   // watchdog: ends a hung run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("project_event_stream_deframer: mismatch");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_in_byte <= 8'h00;
      csr_we <= 1'b0;
      csr_index <= CSR_WORD_ID_BASE;
      csr_wdata <= 8'h00;
      board = new();
      idle_on = 1;
      bytes_sent = 0;
      settings_used = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // only one reset per run, so a header fault ends the useful stream;
      // draw one now and then so every header error code gets its turn
      header_fault = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
      send_header(header_fault);

      if (header_fault != 0) begin
         // parser must stay silent after the error, over a full-length stream
         drain();
         repeat (SETTING_COUNT * BYTES_PER_SETTING) send_byte(rand_byte());
      end else begin
         // directed events at reset bases: class edges, payload extremes,
         // zero-length text, and a padded two-byte varint
         send_event(8'h00, 32'h0000_00FF, 0);
         send_event(8'h3F, 32'h0000_0000, 0);
         send_event(8'h40, 32'h0000_FFFF, 0);
         send_event(8'hBF, 32'hFFFF_FFFF, 0);
         send_event(8'hC0, 32'd0, 0);
         send_event(8'hFF, 32'd2, 2);

         for (int s = 0; s < SETTING_COUNT; s++) begin
            // bases change only with nothing in flight
            drain();
            case (s)
               0: begin w_base = 8'd0;   d_base = 8'd0;   t_base = 8'd0;   end
               1: begin w_base = 8'd255; d_base = 8'd255; t_base = 8'd255; end
               2: begin w_base = 8'd200; d_base = 8'd100; t_base = 8'd50;  end
               3: begin w_base = 8'd64;  d_base = 8'd128; t_base = 8'd192; end
               default: begin
                  w_base = 8'($urandom);
                  d_base = 8'($urandom);
                  t_base = 8'($urandom);
               end
            endcase
            write_bases(w_base, d_base, t_base);
            // no idling at all in the last stretch
            idle_on = (s != SETTING_COUNT - 1);
            phase_end = bytes_sent + BYTES_PER_SETTING;
            while (bytes_sent < phase_end) begin
               case ($urandom_range(0, 3))
                  0, 1: ev_id = 8'($urandom);
                  2: begin
                     // hug the class thresholds
                     case ($urandom_range(0, 2))
                        0: ev_id = board.word_base;
                        1: ev_id = board.dword_base;
                        default: ev_id = board.text_base;
                     endcase
                     ev_id = ev_id + 8'($urandom_range(0, 2)) - 8'd1;
                  end
                  default: ev_id = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               endcase
               if (board.payload_kind(ev_id) == KIND_TEXT_START)
                  ev_payload = ($urandom_range(0, 23) == 0) ? $urandom_range(120, 140)
                                                            : $urandom_range(0, 12);
               else
                  ev_payload = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
               send_event(ev_id, ev_payload, $urandom_range(0, 5));
            end
         end

         // close with a varint length that runs past 32 bits
         send_byte(8'hFF);
         repeat (4) send_byte(8'h80 | 8'($urandom_range(0, 127)));
         send_byte(8'($urandom_range(16, 255)));
         repeat (10) send_byte(rand_byte());
      end

      drain();
      repeat (8) @(posedge clock);

      $display("run covered %0d stream bytes, %0d checked results, %0d id base settings",
               bytes_sent, results_seen, settings_used);
      $display("stream closed by %s",
               (header_fault != 0) ? "a corrupted header chunk" : "a varint length overflow");
      if (board.mismatch_count == 0)
         $display("project_event_stream_deframer: match");
      else
         $display("project_event_stream_deframer: mismatch");
      $finish;
   end

endmodule
